// ===== rtl/c3f_pkg.sv =====
package c3f_pkg;

  localparam int PIX_W        = 16;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = PIX_W + COEF_W;
  localparam int SUM_W        = 35;
  localparam int ROW_W        = 16;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int COEF_ROW_W   = 3 * COEF_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = COEF_ROW_W;
  localparam int BORDER_SHIFT = 12;
  localparam int TAPS         = 9;
  localparam int MIN_DIM      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_COEF_TOP = 3'd2,
    REG_COEF_MID = 3'd3,
    REG_COEF_BOT = 3'd4
  } cfg_reg_t;

  // Position and kind of the pixel travelling down the pipeline.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    border;
    logic                    filt;
    logic signed [PIX_W-1:0] pix;
  } tag_t;

  // Window and kernel, tap k = 3 * kernel_row + kernel_col.
  typedef logic [TAPS-1:0][PIX_W-1:0]  win_t;
  typedef logic [TAPS-1:0][COEF_W-1:0] coef_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    border;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/c3f_pixel_if.sv =====
interface c3f_pixel_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3f_pkg::PIX_W-1:0]    pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/c3f_result_if.sv =====
interface c3f_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3f_pkg::SUM_W-1:0]    pixel_out;
  logic [c3f_pkg::ROW_W-1:0]           out_row;
  logic [c3f_pkg::COL_W-1:0]           out_col;
  logic                                is_border;
  logic                                last_of_run;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output is_border, output last_of_run, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input is_border, input last_of_run, output ready);
endinterface

// ===== rtl/c3f_cfg_if.sv =====
interface c3f_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [c3f_pkg::CFG_IDX_W-1:0]       index;
  logic [c3f_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/c3f_line_mem.sv =====
module c3f_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/c3f_kernel.sv =====
module c3f_kernel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             a_valid,
  input  c3f_pkg::tag_t                    a_tag,
  input  c3f_pkg::win_t                    win,
  input  c3f_pkg::coef_t                   coef,
  output logic                             c_valid,
  output c3f_pkg::tag_t                    c_tag,
  output logic signed [c3f_pkg::SUM_W-1:0] c_sum
);

  logic                                   b_valid;
  c3f_pkg::tag_t                          b_tag;
  logic signed [c3f_pkg::PROD_W-1:0]      prod [c3f_pkg::TAPS];
  logic signed [c3f_pkg::SUM_W-1:0]       row_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // Nine products in one stage, then one adder per kernel row.
  always_ff @(posedge clk) begin
    if (advance) begin
      b_tag <= a_tag;
      for (int k = 0; k < c3f_pkg::TAPS; k++) begin
        prod[k] <= $signed(win[k]) * $signed(coef[k]);
      end
      c_tag <= b_tag;
      for (int x = 0; x < 3; x++) begin
        row_sum[x] <= c3f_pkg::SUM_W'(prod[3*x]) + c3f_pkg::SUM_W'(prod[3*x+1])
                      + c3f_pkg::SUM_W'(prod[3*x+2]);
      end
    end
  end

  assign c_sum = row_sum[0] + row_sum[1] + row_sum[2];

endmodule

// ===== rtl/c3f_result_buf.sv =====
module c3f_result_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             c_valid,
  input  c3f_pkg::tag_t                    c_tag,
  input  logic signed [c3f_pkg::SUM_W-1:0] c_sum,
  output logic                             advance,
  c3f_result_if.source                     results
);

  localparam int EXT_W = c3f_pkg::SUM_W - c3f_pkg::PIX_W - c3f_pkg::BORDER_SHIFT;

  logic [1:0]     o_cnt;
  c3f_pkg::res_t  q0;
  c3f_pkg::res_t  q1;
  logic [1:0]     c_cnt;
  logic           pop;
  logic           load;
  c3f_pkg::res_t  border_res;
  c3f_pkg::res_t  filt_res;

  assign c_cnt   = {1'b0, c_tag.border} + {1'b0, c_tag.filt};
  assign pop     = (o_cnt != 2'd0) && results.ready;
  // The pipeline moves when the last stage has nothing to hand over, or when
  // the holding register will be empty after this cycle.
  assign advance = !c_valid || (c_cnt == 2'd0) || (o_cnt == 2'd0)
                   || ((o_cnt == 2'd1) && results.ready);
  assign load    = advance && c_valid && (c_cnt != 2'd0);

  always_comb begin
    border_res.value  = {{EXT_W{c_tag.pix[c3f_pkg::PIX_W-1]}}, c_tag.pix,
                         {c3f_pkg::BORDER_SHIFT{1'b0}}};
    border_res.row    = c_tag.row;
    border_res.col    = c_tag.col;
    border_res.border = 1'b1;
    border_res.last   = !c_tag.filt;
    filt_res.value    = c_sum;
    filt_res.row      = c_tag.row - c3f_pkg::ROW_W'(1);
    filt_res.col      = c_tag.col - c3f_pkg::COL_W'(1);
    filt_res.border   = 1'b0;
    filt_res.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= 2'd0;
    end else if (load) begin
      o_cnt <= c_cnt;
    end else if (pop) begin
      o_cnt <= o_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0 <= c_tag.border ? border_res : filt_res;
      q1 <= filt_res;
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign results.valid       = (o_cnt != 2'd0);
  assign results.pixel_out   = q0.value;
  assign results.out_row     = q0.row;
  assign results.out_col     = q0.col;
  assign results.is_border   = q0.border;
  assign results.last_of_run = q0.last;

endmodule

// ===== rtl/conv3x3_image_filter_unit.sv =====
// A pixel accepted on the input shows its first request on the result channel after
// the product stage, the row-sum stage and the result register. Throughput: one pixel
// per clock while the result channel is ready; a pixel that causes two results (last
// column or last row, from row 2 and column 2 on) stalls the input when a pixel with a
// result follows it, as the result channel moves one request per clock. Synchronous reset
// empties the pipeline, clears position and window, restores the registers, not line memory.
module conv3x3_image_filter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  c3f_pixel_if.sink     pixels,
  c3f_result_if.source  results,
  c3f_cfg_if.sink       cfg
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = (CW > c3f_pkg::WIDTH_REG_W) ? CW : c3f_pkg::WIDTH_REG_W;
  localparam int PW = c3f_pkg::PIX_W;
  localparam int RW = c3f_pkg::ROW_W;
  localparam int CFW = c3f_pkg::COEF_W;

  logic [c3f_pkg::WIDTH_REG_W-1:0] width_reg;
  logic [RW-1:0]                   height_reg;
  logic [c3f_pkg::COEF_ROW_W-1:0]  coef_row [3];

  logic [AW-1:0]  col_count;
  logic [RW-1:0]  row_count;
  logic [AW-1:0]  col_count_next;
  logic [RW-1:0]  row_count_next;

  logic [WW-1:0]  width_ext;
  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [AW-1:0]  c0;
  logic [RW-1:0]  r0;
  logic [RW:0]    r_inc;
  logic [CW-1:0]  c_plus;
  logic [RW:0]    r_plus;

  logic           advance;
  logic           accept;
  logic           a_valid;
  c3f_pkg::tag_t  a_tag;
  logic [AW-1:0]  a_addr;
  logic [PW-1:0]  win_col [6];
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]  top;
  logic [PW-1:0]  mid;
  c3f_pkg::win_t  win;
  c3f_pkg::coef_t coef;

  logic           c_valid;
  c3f_pkg::tag_t  c_tag;
  logic signed [c3f_pkg::SUM_W-1:0] c_sum;

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg   <= c3f_pkg::WIDTH_REG_W'(1024);
      height_reg  <= RW'(1024);
      coef_row[0] <= '0;
      coef_row[1] <= '0;
      coef_row[2] <= '0;
    end else if (cfg.valid) begin
      unique case (c3f_pkg::cfg_reg_t'(cfg.index))
        c3f_pkg::REG_WIDTH:    width_reg   <= cfg.data[c3f_pkg::WIDTH_REG_W-1:0];
        c3f_pkg::REG_HEIGHT:   height_reg  <= cfg.data[RW-1:0];
        c3f_pkg::REG_COEF_TOP: coef_row[0] <= cfg.data;
        c3f_pkg::REG_COEF_MID: coef_row[1] <= cfg.data;
        c3f_pkg::REG_COEF_BOT: coef_row[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Geometry in use: width clamped to what the line memory holds, both raised to MIN_DIM.
  always_comb begin
    width_ext = WW'(width_reg);
    if (width_ext < WW'(c3f_pkg::MIN_DIM)) begin
      w_eff = CW'(c3f_pkg::MIN_DIM);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext[CW-1:0];
    end
    h_eff = (height_reg < RW'(c3f_pkg::MIN_DIM)) ? RW'(c3f_pkg::MIN_DIM) : height_reg;
  end

  // Position of the incoming pixel. A count left beyond a shrunk geometry
  // wraps before use.
  always_comb begin
    if (CW'(col_count) >= w_eff) begin
      c0    = '0;
      r_inc = {1'b0, row_count} + (RW+1)'(1);
    end else begin
      c0    = col_count;
      r_inc = {1'b0, row_count};
    end
    r0 = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[RW-1:0];

    c_plus = CW'(c0) + CW'(1);
    r_plus = {1'b0, r0} + (RW+1)'(1);
    if (c_plus >= w_eff) begin
      col_count_next = '0;
      row_count_next = (r_plus >= {1'b0, h_eff}) ? '0 : r_plus[RW-1:0];
    end else begin
      col_count_next = c_plus[AW-1:0];
      row_count_next = r0;
    end
  end

  assign pixels.ready = advance;
  assign accept       = pixels.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      a_valid   <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (advance) begin
        a_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_tag.row    <= r0;
      a_tag.col    <= c3f_pkg::COL_W'(c0);
      a_tag.border <= (r0 == '0) || (r0 == h_eff - RW'(1)) || (c0 == '0)
                      || (CW'(c0) == w_eff - CW'(1));
      a_tag.filt   <= (r0 >= RW'(2)) && (c0 >= AW'(2));
      a_tag.pix    <= pixels.pixel_in;
      a_addr       <= c0;
    end
  end

  // Each column entry holds the two rows above: upper half two rows up.
  c3f_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (2 * PW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (rd_data),
    .wr_en   (advance && a_valid),
    .wr_addr (a_addr),
    .wr_data ({mid, a_tag.pix})
  );

  assign top = rd_data[2*PW-1:PW];
  assign mid = rd_data[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win_col[i] <= '0;
      end
    end else if (advance && a_valid) begin
      win_col[0] <= win_col[3];
      win_col[1] <= win_col[4];
      win_col[2] <= win_col[5];
      win_col[3] <= top;
      win_col[4] <= mid;
      win_col[5] <= a_tag.pix;
    end
  end

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      win[3*x]     = win_col[x];
      win[3*x + 1] = win_col[3 + x];
      for (int y = 0; y < 3; y++) begin
        coef[3*x + y] = coef_row[x][CFW*y +: CFW];
      end
    end
    win[2] = top;
    win[5] = mid;
    win[8] = a_tag.pix;
  end

  c3f_kernel u_kernel (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .a_valid (a_valid),
    .a_tag   (a_tag),
    .win     (win),
    .coef    (coef),
    .c_valid (c_valid),
    .c_tag   (c_tag),
    .c_sum   (c_sum)
  );

  c3f_result_buf u_result_buf (
    .clk     (clk),
    .rst     (rst),
    .c_valid (c_valid),
    .c_tag   (c_tag),
    .c_sum   (c_sum),
    .advance (advance),
    .results (results)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH     = 1024;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 650;

  logic clk = 1'b0;
  logic rst;

  c3f_pixel_if  pix_if();
  c3f_result_if res_if();
  c3f_cfg_if    cfg_if();

  conv3x3_image_filter_unit #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  // Mirror of the filter state, advanced once per accepted pixel.
  logic [c3f_pkg::PIX_W-1:0]       line_mem [2*MAX_WIDTH];
  logic [c3f_pkg::PIX_W-1:0]       win_cols [6];
  int unsigned                     next_col;
  int unsigned                     next_row;
  logic [c3f_pkg::WIDTH_REG_W-1:0] width_reg;
  logic [c3f_pkg::ROW_W-1:0]       height_reg;
  logic [c3f_pkg::COEF_ROW_W-1:0]  kernel_rows [3];

  c3f_pkg::res_t pending_out [$];
  int   errors      = 0;
  int   pixels_sent = 0;
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   stall_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int active_width();
    int w;
    w = width_reg;
    if (w < c3f_pkg::MIN_DIM) w = c3f_pkg::MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = height_reg;
    if (h < c3f_pkg::MIN_DIM) h = c3f_pkg::MIN_DIM;
    return h;
  endfunction

  function automatic logic [c3f_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return c3f_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [c3f_pkg::COEF_ROW_W-1:0] random_kernel_row();
    logic [c3f_pkg::COEF_ROW_W-1:0] row;
    for (int k = 0; k < 3; k++) begin
      row[c3f_pkg::COEF_W*k +: c3f_pkg::COEF_W] = random_pixel();
    end
    return row;
  endfunction

  // Works out the results caused by one pixel: the pass-through value when the
  // pixel sits on the border, then, from row 2 and column 2 on, the filtered centre one row up and one left.
  function automatic void filter_pixel(logic [c3f_pkg::PIX_W-1:0] pix);
    int unsigned               w, h, r, c;
    logic [c3f_pkg::PIX_W-1:0] top, mid;
    logic [c3f_pkg::PIX_W-1:0] win [3][3];
    longint                    acc;
    c3f_pkg::res_t             o;
    bit                        emitted;
    w = active_width();
    h = active_height();
    emitted = 1'b0;
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    r = next_row;
    c = next_col;
    top = line_mem[MAX_WIDTH + c];
    mid = line_mem[c];
    line_mem[MAX_WIDTH + c] = mid;
    line_mem[c] = pix;
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      o.value  = c3f_pkg::SUM_W'(longint'($signed(pix)) <<< c3f_pkg::BORDER_SHIFT);
      o.row    = c3f_pkg::ROW_W'(r);
      o.col    = c3f_pkg::COL_W'(c);
      o.border = 1'b1;
      o.last   = 1'b0;
      pending_out.push_back(o);
      emitted = 1'b1;
    end
    if (r >= 2 && c >= 2) begin
      for (int x = 0; x < 3; x++) begin
        win[x][0] = win_cols[x];
        win[x][1] = win_cols[3 + x];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      acc = 0;
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          acc += longint'($signed(win[x][y])) *
                 longint'($signed(kernel_rows[x][c3f_pkg::COEF_W*y +: c3f_pkg::COEF_W]));
        end
      end
      o.value  = acc[c3f_pkg::SUM_W-1:0];
      o.row    = c3f_pkg::ROW_W'(r - 1);
      o.col    = c3f_pkg::COL_W'(c - 1);
      o.border = 1'b0;
      o.last   = 1'b0;
      pending_out.push_back(o);
      emitted = 1'b1;
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = pix;
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
    if (emitted) pending_out[pending_out.size() - 1].last = 1'b1;
  endfunction

  // Leaves valid high so that back-to-back writes run without valid dropping in between.
  task automatic write_reg(c3f_pkg::cfg_reg_t idx, logic [c3f_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      c3f_pkg::REG_WIDTH:    width_reg      = value[c3f_pkg::WIDTH_REG_W-1:0];
      c3f_pkg::REG_HEIGHT:   height_reg     = value[c3f_pkg::ROW_W-1:0];
      c3f_pkg::REG_COEF_TOP: kernel_rows[0] = value;
      c3f_pkg::REG_COEF_MID: kernel_rows[1] = value;
      c3f_pkg::REG_COEF_BOT: kernel_rows[2] = value;
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [c3f_pkg::PIX_W-1:0] pix);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= pix;
    do @(posedge clk); while (!pix_if.ready);
    filter_pixel(pix);
    pixels_sent++;
  endtask

  // Pixels without a result may still be in the pipeline once the last
  // expected request has been seen, so the task goes on waiting after the queue is empty.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic finish_frame();
    do begin
      send_pixel(random_pixel());
    end while (next_row != 0 || next_col != 0);
  endtask

  // Default geometry and an all-zero kernel; leaves the frame partly sent.
  task automatic test_reset_state();
    gap_pct   = 0;
    stall_pct = 0;
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h5555);
    wait_idle();
  endtask

  task automatic test_value_extremes();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(c3f_pkg::REG_WIDTH, 3);
    write_reg(c3f_pkg::REG_HEIGHT, 3);
    write_reg(c3f_pkg::REG_COEF_TOP, {3{16'h8000}});
    write_reg(c3f_pkg::REG_COEF_MID, {3{16'h8000}});
    write_reg(c3f_pkg::REG_COEF_BOT, {3{16'h8000}});
    cfg_if.valid <= 1'b0;
    // The column count is past the new width, so the frame wraps to row 1.
    finish_frame();
    repeat (9) send_pixel(16'h8000);
    wait_idle();
    write_reg(c3f_pkg::REG_WIDTH, 0);
    write_reg(c3f_pkg::REG_HEIGHT, 1);
    cfg_if.valid <= 1'b0;
    repeat (9) send_pixel(16'h7FFF);
    wait_idle();
    write_reg(c3f_pkg::REG_WIDTH, 2);
    write_reg(c3f_pkg::REG_HEIGHT, 0);
    write_reg(c3f_pkg::REG_COEF_TOP, {3{16'h7FFF}});
    write_reg(c3f_pkg::REG_COEF_MID, {3{16'h7FFF}});
    write_reg(c3f_pkg::REG_COEF_BOT, {3{16'h7FFF}});
    cfg_if.valid <= 1'b0;
    repeat (9) send_pixel(16'h7FFF);
    wait_idle();
  endtask

  task automatic test_kernel_taps();
    gap_pct   = 30;
    stall_pct = 30;
    write_reg(c3f_pkg::REG_WIDTH, 5);
    write_reg(c3f_pkg::REG_HEIGHT, 4);
    write_reg(c3f_pkg::REG_COEF_TOP, random_kernel_row());
    write_reg(c3f_pkg::REG_COEF_MID, random_kernel_row());
    write_reg(c3f_pkg::REG_COEF_BOT, random_kernel_row());
    cfg_if.valid <= 1'b0;
    finish_frame();
    wait_idle();
  endtask

  // Clamped full width with the tallest frame, then both shrunk mid-frame.
  task automatic test_wide_row();
    gap_pct   = 10;
    stall_pct = 10;
    write_reg(c3f_pkg::REG_WIDTH, 2047);
    write_reg(c3f_pkg::REG_HEIGHT, 65535);
    cfg_if.valid <= 1'b0;
    repeat (MAX_WIDTH + 3) send_pixel(random_pixel());
    wait_idle();
    write_reg(c3f_pkg::REG_WIDTH, 3);
    write_reg(c3f_pkg::REG_HEIGHT, 3);
    cfg_if.valid <= 1'b0;
    finish_frame();
    wait_idle();
  endtask

  task automatic test_tall_frame();
    gap_pct   = 20;
    stall_pct = 0;
    write_reg(c3f_pkg::REG_WIDTH, 4);
    write_reg(c3f_pkg::REG_HEIGHT, 65535);
    cfg_if.valid <= 1'b0;
    repeat (22) send_pixel(random_pixel());
    wait_idle();
    // Row 5 is beyond the new height, so the position wraps to row 0.
    write_reg(c3f_pkg::REG_HEIGHT, 3);
    cfg_if.valid <= 1'b0;
    finish_frame();
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int part;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if ($urandom_range(3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(50, 5);
        stall_pct = $urandom_range(50, 5);
      end
      case ($urandom_range(9))
        0: w = $urandom_range(2, 0);
        1: w = $urandom_range(40, 13);
        default: w = $urandom_range(12, 3);
      endcase
      h = ($urandom_range(7) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
      write_reg(c3f_pkg::REG_WIDTH, w);
      write_reg(c3f_pkg::REG_HEIGHT, h);
      if ($urandom_range(1) == 1) begin
        write_reg(c3f_pkg::REG_COEF_TOP, random_kernel_row());
        write_reg(c3f_pkg::REG_COEF_MID, random_kernel_row());
        write_reg(c3f_pkg::REG_COEF_BOT, random_kernel_row());
      end
      cfg_if.valid <= 1'b0;
      if ($urandom_range(3) == 0) begin
        // Shrinking only, so every line entry read later was written in this frame.
        part = $urandom_range(active_width() * active_height() - 1, 1);
        repeat (part) send_pixel(random_pixel());
        wait_idle();
        write_reg(c3f_pkg::REG_WIDTH, $urandom_range(active_width(), c3f_pkg::MIN_DIM));
        write_reg(c3f_pkg::REG_HEIGHT, $urandom_range(active_height(), c3f_pkg::MIN_DIM));
        cfg_if.valid <= 1'b0;
        finish_frame();
      end else begin
        repeat ($urandom_range(2, 1)) finish_frame();
      end
      wait_idle();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left   <= idle_len() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    c3f_pkg::res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_out.size() == 0) begin
        $error("unexpected result request: row %0d col %0d value %0d",
               res_if.out_row, res_if.out_col, res_if.pixel_out);
        errors++;
      end else begin
        want = pending_out.pop_front();
        if (res_if.pixel_out !== want.value) begin
          $error("pixel_out: expected %0d, got %0d", want.value, res_if.pixel_out);
          errors++;
        end
        if (res_if.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, res_if.out_row);
          errors++;
        end
        if (res_if.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, res_if.out_col);
          errors++;
        end
        if (res_if.is_border !== want.border) begin
          $error("is_border: expected %0b, got %0b", want.border, res_if.is_border);
          errors++;
        end
        if (res_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, res_if.last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    rst             <= 1'b1;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= c3f_pkg::REG_WIDTH;
    cfg_if.data     <= '0;
    for (int k = 0; k < 2 * MAX_WIDTH; k++) line_mem[k] = '0;
    for (int k = 0; k < 6; k++) win_cols[k] = '0;
    for (int k = 0; k < 3; k++) kernel_rows[k] = '0;
    next_col   = 0;
    next_row   = 0;
    width_reg  = c3f_pkg::WIDTH_REG_W'(MAX_WIDTH);
    height_reg = c3f_pkg::ROW_W'(1024);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_value_extremes();
    test_kernel_taps();
    test_wide_row();
    test_tall_frame();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
